[design/murmur64a_stream_hash_top_defines.svh]
// Assertion macros shared by the murmur64a stream hash RTL.
// No dependencies; included by modules that carry assertions.
`ifndef MURMUR64A_STREAM_HASH_TOP_DEFINES_SVH
`define MURMUR64A_STREAM_HASH_TOP_DEFINES_SVH

// same-cycle implication
`define M64H_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define M64H_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/m64h_pkg.sv]
// Types, constants and helpers for the murmur64a stream hash.
// No dependencies.
package m64h_pkg;

    localparam logic [63:0] MIX_MUL       = 64'hC6A4_A793_5BD1_E995;
    localparam int          MIX_SHIFT     = 47;
    localparam logic [63:0] SEED_AT_RESET = 64'hDECA_FBAD_DECA_FBAD;
    localparam logic [3:0]  FULL_BYTES    = 4'd8;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISP,
        S_LEN,
        S_K1,
        S_K2,
        S_H,
        S_FIN,
        S_EMIT
    } hash_state_t;

    typedef enum logic [1:0] {
        MS_LL,
        MS_LH,
        MS_HL
    } mul_step_t;

    // mask of the low n bytes, n in 0..8
    function automatic logic [63:0] byte_keep(input logic [3:0] n);
        logic [63:0] keep;
        unique case (n)
            4'd0:    keep = 64'h0000_0000_0000_0000;
            4'd1:    keep = 64'h0000_0000_0000_00FF;
            4'd2:    keep = 64'h0000_0000_0000_FFFF;
            4'd3:    keep = 64'h0000_0000_00FF_FFFF;
            4'd4:    keep = 64'h0000_0000_FFFF_FFFF;
            4'd5:    keep = 64'h0000_00FF_FFFF_FFFF;
            4'd6:    keep = 64'h0000_FFFF_FFFF_FFFF;
            4'd7:    keep = 64'h00FF_FFFF_FFFF_FFFF;
            default: keep = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return keep;
    endfunction

    function automatic logic [63:0] xor_shift(input logic [63:0] x);
        return x ^ (x >> MIX_SHIFT);
    endfunction

endpackage

[design/murmur64a_stream_hash_top.sv]
// Top level of the murmur64a stream hash: handshakes, sequencer, accumulator.
// Uses m64h_pkg, m64h_mul and the defines header.
// A request is taken only while the block is idle and then runs alone: all
// 64-bit products go through one shared 32x32 multiplier, three partial
// products per product. A request is dispatched and then takes three products
// for a full word, one for 1 to 7 bytes and none for none; a first word adds a
// length product and a second dispatch, a last word adds a finalisation
// product and the load of the result register, which waits while an earlier
// hash still waits to be taken. The result register lets the next request
// start while a hash waits to be taken.
`include "murmur64a_stream_hash_top_defines.svh"

module murmur64a_stream_hash_top
    import m64h_pkg::*;
#(
    parameter int LENGTH_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [63:0] cfg_write_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] data_word,
    input  logic [3:0]  word_bytes,
    input  logic [31:0] message_length,
    input  logic        first_word,
    input  logic        last_word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] hash_value
);

    localparam int          LEN_KEEP = (LENGTH_BITS < 32) ? LENGTH_BITS : 32;
    localparam logic [31:0] LEN_MASK = 32'hFFFF_FFFF >> (32 - LEN_KEEP);

    hash_state_t state_reg, state_next;
    logic        started_reg, started_next;
    logic        first_reg, first_next;
    logic        last_reg, last_next;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] seed_reg, seed_next;
    logic [63:0] h_reg, h_next;
    logic [63:0] t_reg, t_next;
    logic [63:0] data_reg, data_next;
    logic [3:0]  nbytes_reg, nbytes_next;
    logic [31:0] len_reg, len_next;
    logic [63:0] hash_reg, hash_next;

    logic        mul_start;
    logic [63:0] mul_operand;
    logic        mul_done;
    logic [63:0] mul_result;
    logic        in_take;
    logic        out_free;
    logic        mul_state;

    m64h_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .operand (mul_operand),
        .done    (mul_done),
        .result  (mul_result)
    );

    assign in_take   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign mul_state = (state_reg == S_LEN) || (state_reg == S_K1) || (state_reg == S_K2)
                    || (state_reg == S_H) || (state_reg == S_FIN);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_take)
                    state_next = S_DISP;
            S_DISP:
            begin
                priority if (first_reg)
                    state_next = S_LEN;
                else if (nbytes_reg == FULL_BYTES)
                    state_next = S_K1;
                else if (nbytes_reg != 4'd0)
                    state_next = S_H;
                else if (last_reg)
                    state_next = S_FIN;
                else
                    state_next = S_IDLE;
            end
            S_LEN:
                if (mul_done)
                    state_next = S_DISP;
            S_K1:
                if (mul_done)
                    state_next = S_K2;
            S_K2:
                if (mul_done)
                    state_next = S_H;
            S_H:
                if (mul_done)
                    state_next = last_reg ? S_FIN : S_IDLE;
            S_FIN:
                if (mul_done)
                    state_next = S_EMIT;
            S_EMIT:
                if (out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_stall    = (state_reg != S_IDLE);
        mul_start   = mul_state && !started_reg;
        mul_operand = h_reg;
        unique case (state_reg)
            S_LEN:   mul_operand = {32'h0, len_reg};
            S_K1:    mul_operand = data_reg;
            S_K2:    mul_operand = xor_shift(t_reg);
            S_FIN:   mul_operand = xor_shift(h_reg);
            default: mul_operand = h_reg;
        endcase
    end

    // datapath
    always_comb
    begin
        started_next   = started_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && out_stall;
        seed_next      = cfg_write_en ? cfg_write_data : seed_reg;
        h_next         = h_reg;
        t_next         = t_reg;
        data_next      = data_reg;
        nbytes_next    = nbytes_reg;
        len_next       = len_reg;
        hash_next      = hash_reg;

        if (mul_start)
            started_next = 1'b1;
        else if (mul_done)
            started_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
                if (in_take)
                begin
                    data_next   = data_word;
                    nbytes_next = (word_bytes > FULL_BYTES) ? FULL_BYTES : word_bytes;
                    len_next    = message_length & LEN_MASK;
                    first_next  = first_word;
                    last_next   = last_word;
                end
            S_DISP:
                if (!first_reg && nbytes_reg != FULL_BYTES && nbytes_reg != 4'd0)
                    h_next = h_reg ^ (data_reg & byte_keep(nbytes_reg));
            S_LEN:
                if (mul_done)
                begin
                    h_next     = seed_reg ^ mul_result;
                    first_next = 1'b0;
                end
            S_K1:
                if (mul_done)
                    t_next = mul_result;
            S_K2:
                if (mul_done)
                    h_next = h_reg ^ mul_result;
            S_H:
                if (mul_done)
                    h_next = mul_result;
            S_FIN:
                if (mul_done)
                    t_next = xor_shift(mul_result);
            S_EMIT:
                if (out_free)
                begin
                    hash_next      = t_reg;
                    out_valid_next = 1'b1;
                end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            started_reg   <= 1'b0;
            first_reg     <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            seed_reg      <= SEED_AT_RESET;
            h_reg         <= 64'h0;
        end
        else
        begin
            state_reg     <= state_next;
            started_reg   <= started_next;
            first_reg     <= first_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
            seed_reg      <= seed_next;
            h_reg         <= h_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg      <= t_next;
        data_reg   <= data_next;
        nbytes_reg <= nbytes_next;
        len_reg    <= len_next;
        hash_reg   <= hash_next;
    end

    assign out_valid  = out_valid_reg;
    assign hash_value = hash_reg;

    `M64H_ASSERT_NOW(a_done_in_mul, mul_done, mul_state && started_reg,
                     "multiply done outside a multiply step")
    `M64H_ASSERT_NEXT(a_take_disp, in_take, state_reg == S_DISP,
                      "accepted request did not reach dispatch")
    `M64H_ASSERT_NEXT(a_emit_loads, state_reg == S_EMIT && out_free,
                      out_valid_reg && state_reg == S_IDLE, "hash not loaded on emit")
    `M64H_ASSERT_NOW(a_start_once, mul_start, !started_reg,
                     "multiply issued twice in one step")

endmodule

[design/m64h_mul.sv]
// Iterative 64-bit multiply by the mixing constant, low 64 bits kept.
// One 32x32 partial product per cycle; uses m64h_pkg and the defines header.
`include "murmur64a_stream_hash_top_defines.svh"

module m64h_mul
    import m64h_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] operand,
    output logic        done,
    output logic [63:0] result
);

    logic        active_reg, active_next;
    logic        done_reg, done_next;
    mul_step_t   step_reg, step_next;
    logic [63:0] a_reg, a_next;
    logic [63:0] acc_reg, acc_next;
    logic [31:0] op_a, op_b;
    logic [63:0] prod;

    always_comb
    begin
        unique case (step_reg)
            MS_LL:
            begin
                op_a = a_reg[31:0];
                op_b = MIX_MUL[31:0];
            end
            MS_LH:
            begin
                op_a = a_reg[31:0];
                op_b = MIX_MUL[63:32];
            end
            default:
            begin
                op_a = a_reg[63:32];
                op_b = MIX_MUL[31:0];
            end
        endcase
    end

    assign prod = 64'(op_a) * 64'(op_b);

    always_comb
    begin
        active_next = active_reg;
        done_next   = 1'b0;
        step_next   = step_reg;
        a_next      = a_reg;
        acc_next    = acc_reg;
        if (start)
        begin
            active_next = 1'b1;
            step_next   = MS_LL;
            a_next      = operand;
        end
        else if (active_reg)
        begin
            unique case (step_reg)
                MS_LL:
                begin
                    acc_next  = prod;
                    step_next = MS_LH;
                end
                MS_LH:
                begin
                    acc_next  = acc_reg + {prod[31:0], 32'h0};
                    step_next = MS_HL;
                end
                default:
                begin
                    acc_next    = acc_reg + {prod[31:0], 32'h0};
                    active_next = 1'b0;
                    done_next   = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            step_reg   <= MS_LL;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            step_reg   <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        acc_reg <= acc_next;
    end

    assign done   = done_reg;
    assign result = acc_reg;

    `M64H_ASSERT_NOW(a_start_idle, start, !active_reg, "multiply started while busy")
    `M64H_ASSERT_NEXT(a_last_done, active_reg && step_reg == MS_HL && !start, done_reg,
                      "last partial product gave no done")
    `M64H_ASSERT_NOW(a_done_idle, done_reg, !active_reg, "done while still active")

endmodule

[test/murmur64a_stream_hash_checker.sv]
// Checker for the murmur64a stream hash: watches the request and hash channels,
// keeps its own accumulator and seed, and compares every hash taken.
// Depends on m64h_pkg for the mix constants.
module murmur64a_stream_hash_checker
    import m64h_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [63:0] cfg_write_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [63:0] data_word,
    input  logic [3:0]  word_bytes,
    input  logic [31:0] message_length,
    input  logic        first_word,
    input  logic        last_word,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [63:0] hash_value,
    output int          error_count,
    output int          hashes_pending,
    output int          hashes_checked,
    output int          words_taken
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [63:0] seed_model;
    logic [63:0] acc_model;
    logic [63:0] expected_hashes[$];

    function automatic logic [63:0] scramble_word(input logic [63:0] k);
        logic [63:0] t;
        t = k * MIX_MUL;
        t = t ^ (t >> MIX_SHIFT);
        t = t * MIX_MUL;
        return t;
    endfunction

    function automatic logic [63:0] finish_hash(input logic [63:0] h);
        logic [63:0] t;
        t = h ^ (h >> MIX_SHIFT);
        t = t * MIX_MUL;
        t = t ^ (t >> MIX_SHIFT);
        return t;
    endfunction

    // accumulator after one request word
    function automatic logic [63:0] fold_word(
        input logic [63:0] acc,
        input logic [63:0] seed,
        input logic [63:0] data,
        input logic [3:0]  nbytes,
        input logic [31:0] len,
        input logic        is_first
    );
        logic [63:0] h;
        logic [63:0] keep;
        int          n;
        n = (nbytes > FULL_BYTES) ? 8 : int'(nbytes);
        h = acc;
        if (is_first)
            h = seed ^ ({32'd0, len} * MIX_MUL);
        if (n == 8)
        begin
            h = h ^ scramble_word(data);
            h = h * MIX_MUL;
        end
        else if (n != 0)
        begin
            keep = (64'd1 << (8 * n)) - 64'd1;
            h = h ^ (data & keep);
            h = h * MIX_MUL;
        end
        return h;
    endfunction

    task automatic queue_hash(input logic [63:0] h);
        expected_hashes = {expected_hashes, h};
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ns murmur64a check: %s got %h expected %h", $time, what, got, want);
        error_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic [63:0] want;
        if (!rst_n)
        begin
            seed_model = SEED_AT_RESET;
            acc_model  = '0;
            expected_hashes.delete();
            hashes_pending = 0;
        end
        else
        begin
            if (cfg_write_en)
                seed_model = cfg_write_data;
            if (out_valid && !out_stall)
            begin
                hashes_checked++;
                if (expected_hashes.size() == 0)
                    report_mismatch("hash with no message pending", hash_value, '0);
                else
                begin
                    want = expected_hashes.pop_front();
                    if (hash_value !== want)
                        report_mismatch("hash_value", hash_value, want);
                end
            end
            if (in_valid && !in_stall)
            begin
                words_taken++;
                acc_model = fold_word(acc_model, seed_model, data_word, word_bytes,
                                      message_length, first_word);
                if (last_word)
                    queue_hash(finish_hash(acc_model));
            end
            hashes_pending = expected_hashes.size();
        end
    end

endmodule

[test/murmur64a_stream_hash_top_test.sv]
// Testbench top for murmur64a_stream_hash_top: clock, reset, seed writes,
// directed and random message requests, output stalls and the verdict.
// Depends on m64h_pkg, the RTL and murmur64a_stream_hash_checker.
module murmur64a_stream_hash_top_test
    import m64h_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE      = 40;

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        cfg_write_en   = 1'b0;
    logic [63:0] cfg_write_data = '0;
    logic        in_valid       = 1'b0;
    logic [63:0] data_word      = '0;
    logic [3:0]  word_bytes     = '0;
    logic [31:0] message_length = '0;
    logic        first_word     = 1'b0;
    logic        last_word      = 1'b0;
    logic        out_stall      = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic [63:0] hash_value;

    int error_count;
    int hashes_pending;
    int hashes_checked;
    int words_taken;

    int cycle_count  = 0;
    int words_sent   = 0;
    bit tx_quiet     = 1'b0;
    bit rx_quiet     = 1'b0;
    int hold_request = 0;

    murmur64a_stream_hash_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_word      (data_word),
        .word_bytes     (word_bytes),
        .message_length (message_length),
        .first_word     (first_word),
        .last_word      (last_word),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .hash_value     (hash_value)
    );

    murmur64a_stream_hash_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_word      (data_word),
        .word_bytes     (word_bytes),
        .message_length (message_length),
        .first_word     (first_word),
        .last_word      (last_word),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .hash_value     (hash_value),
        .error_count    (error_count),
        .hashes_pending (hashes_pending),
        .hashes_checked (hashes_checked),
        .words_taken    (words_taken)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d hashes outstanding",
                     cycle_count, hashes_pending);
            $display("murmur64a_stream_hash_top_test: errors");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // mostly short, a few long
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // hash receiver
    initial
    begin
        bit hold_served;
        hold_served = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request > 0 && !hold_served)
            begin
                out_stall <= 1'b1;
                repeat (hold_request) @(posedge clk);
                hold_served = 1'b1;
                out_stall <= 1'b0;
            end
            else if (!rx_quiet && $urandom_range(0, 99) < 25)
            begin
                out_stall <= 1'b1;
                repeat (idle_length()) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic push_word(input logic [63:0] data, input logic [3:0] nbytes,
                             input logic [31:0] len, input bit is_first, input bit is_last);
        int gap;
        in_valid       <= 1'b1;
        data_word      <= data;
        word_bytes     <= nbytes;
        message_length <= len;
        first_word     <= is_first;
        last_word      <= is_last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
        gap = 0;
        if (!tx_quiet && $urandom_range(0, 99) >= 55)
            gap = idle_length();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop sending and wait until every hash has been taken and the block is idle
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (hashes_pending == 0);
        @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_seed(input logic [63:0] value);
        drain();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
    endtask

    task automatic send_message(input int total, input bit with_first);
        int          full_words;
        int          tail;
        bit          empty_tail;
        logic [31:0] len_field;
        full_words = total / 8;
        tail       = total % 8;
        len_field  = ($urandom_range(0, 19) == 0) ? $urandom : 32'(total);
        empty_tail = (tail == 0) && (full_words > 0) && ($urandom_range(0, 3) == 0);
        if (full_words == 0)
            push_word(rand64(), 4'(tail), len_field, with_first, 1'b1);
        else
        begin
            for (int w = 0; w < full_words; w++)
                push_word(rand64(), FULL_BYTES, (w == 0) ? len_field : $urandom,
                          with_first && (w == 0),
                          (w == full_words - 1) && (tail == 0) && !empty_tail);
            if (tail != 0 || empty_tail)
                push_word(rand64(), 4'(tail), $urandom, 1'b0, 1'b1);
        end
    endtask

    initial
    begin
        int          target;
        int          pick;
        int          msg_bytes;
        logic [63:0] seed;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, seed at its reset value
        push_word('1, FULL_BYTES, '0, 1'b0, 1'b1);               // no first word after reset
        push_word(rand64(), 4'd0, '0, 1'b1, 1'b1);               // empty message
        push_word('0, FULL_BYTES, 32'hFFFF_FFFF, 1'b1, 1'b0);    // longest length field
        push_word('1, 4'd7, $urandom, 1'b0, 1'b1);               // bytes above the count
        for (int n = 1; n < 8; n++)
            push_word(rand64(), 4'(n), 32'(n), 1'b1, 1'b1);
        push_word(rand64(), 4'd9, 32'd16, 1'b1, 1'b0);           // counts above eight
        push_word(rand64(), 4'd15, $urandom, 1'b0, 1'b1);
        push_word(rand64(), 4'd3, 32'd19, 1'b1, 1'b0);           // tail word mid-message
        push_word(rand64(), FULL_BYTES, $urandom, 1'b0, 1'b0);
        push_word(rand64(), 4'd0, $urandom, 1'b0, 1'b1);
        push_word(rand64(), FULL_BYTES, $urandom, 1'b0, 1'b1);   // carries on after a hash
        push_word(rand64(), 4'd0, $urandom, 1'b0, 1'b0);
        push_word(rand64(), 4'd12, $urandom, 1'b1, 1'b1);

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                1:       seed = '0;
                2:       seed = '1;
                5:       seed = SEED_AT_RESET;
                default: seed = rand64();
            endcase
            if (phase > 0)
                write_seed(seed);
            tx_quiet = (phase == 1) || (phase == 3);
            rx_quiet = (phase == 1) || (phase == 4);
            if (phase == 3)
                hold_request = 400;
            target = words_sent + 150;
            while (words_sent < target)
            begin
                pick = $urandom_range(0, 99);
                msg_bytes = $urandom_range(0, 99);
                if (msg_bytes < 85)
                    msg_bytes = $urandom_range(0, 40);
                else if (msg_bytes < 97)
                    msg_bytes = $urandom_range(41, 120);
                else
                    msg_bytes = $urandom_range(121, 400);
                if (pick < 88)
                    send_message(msg_bytes, 1'b1);
                else if (pick < 92)
                    send_message(msg_bytes, 1'b0);
                else
                    push_word(rand64(), 4'($urandom_range(0, 15)), $urandom,
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
        end

        drain();
        $display("covered %0d request words and %0d hashes over six seeds (zero, all ones, reset)",
                 words_taken, hashes_checked);
        $display("with idling and stalls on both channels and one long output hold-off");
        if (error_count == 0)
            $display("murmur64a_stream_hash_top_test: clean");
        else
            $display("murmur64a_stream_hash_top_test: errors");
        $finish;
    end

endmodule
